@@ hdl/assert_macros.svh @@
// Assertion macros shared by the socket table RTL.
// Depends on clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check an implication on every clock edge outside reset
`define SDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/sdt_pkg.sv @@
// Types and constants of the socket lookup table.
// No dependencies.
package sdt_pkg;

  localparam logic [2:0] OP_OPEN        = 3'd0;
  localparam logic [2:0] OP_CLOSE       = 3'd1;
  localparam logic [2:0] OP_BIND        = 3'd2;
  localparam logic [2:0] OP_CONNECT     = 3'd3;
  localparam logic [2:0] OP_LOOKUP_FULL = 3'd4;
  localparam logic [2:0] OP_LOOKUP_LOC  = 3'd5;
  localparam logic [2:0] OP_SPARE_LO    = 3'd6;
  localparam logic [2:0] OP_SPARE_HI    = 3'd7;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOIF      = 3'd1;
  localparam logic [2:0] STAT_EXHAUSTED = 3'd2;
  localparam logic [2:0] STAT_INUSE     = 3'd3;
  localparam logic [2:0] STAT_BADDST    = 3'd4;
  localparam logic [2:0] STAT_NOTFOUND  = 3'd5;

  localparam logic [1:0] CFG_INVALID_IP = 2'd0;
  localparam logic [1:0] CFG_EPH_START  = 2'd1;
  localparam logic [1:0] CFG_SPARE_LO   = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI   = 2'd3;

  localparam logic [15:0] PORT_LOW_DEFAULT = 16'd49152;
  localparam logic [15:0] PORT_TOP         = 16'd65535;
  localparam logic [15:0] PORT_FLOOR       = 16'd1024;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot;
    logic        sock_kind;
    logic [31:0] own_ip;
    logic [15:0] own_port;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic        iface_found;
    logic [15:0] scan_from;
  } sdt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [3:0]  match_slot;
    logic [15:0] bound_port;
  } sdt_out_t;

  typedef struct packed {
    logic        bound;
    logic        connected;
    logic        kind;
    logic        has_iface;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
  } sdt_entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
    logic        full;
  } sdt_query_t;

  typedef struct packed {
    logic start_scan;
    logic finish;
    logic rescan;
    logic next_entry;
  } sdt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FIN
  } sdt_state_e;

  typedef enum logic [1:0] {
    JOB_LOOKUP,
    JOB_AUTO,
    JOB_FIXED
  } sdt_job_e;

endpackage

@@ hdl/sdt_match.sv @@
// Compare unit: matches one table entry against a query.
// Depends on sdt_pkg.
module sdt_match import sdt_pkg::*; (
  input  sdt_entry_t entry_i,
  input  sdt_query_t query_i,
  output logic       hit_o
);

  logic local_hit;
  logic remote_ok;

  assign local_hit = entry_i.bound && (entry_i.kind == query_i.kind) &&
                     (entry_i.lport == query_i.lport) &&
                     (!entry_i.has_iface || (query_i.lip == 32'd0) ||
                      (entry_i.lip == query_i.lip));

  assign remote_ok = entry_i.connected ?
                     ((entry_i.rip == query_i.rip) && (entry_i.rport == query_i.rport)) :
                     ((query_i.rip == 32'd0) && (query_i.rport == 16'd0));

  assign hit_o = local_hit && (!query_i.full || remote_ok);

endmodule

@@ hdl/socket_demux_table_unit.sv @@
// Socket lookup table with automatic port allocation, top level.
// Depends on sdt_pkg, sdt_match and assert_macros.svh.
//
// Input channel in_valid_i/in_ready_o carries one opcode item; output
// channel out_valid_o/out_ready_i returns exactly one result item for it.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
// once: index 0 invalid address, index 1 low end of the automatic port range.
// Open, close, connect, unused opcodes and items rejected before any table
// walk go from acceptance straight to the finish state, from which their
// result is loaded into the result register. Lookups and binds walk the
// table entry by entry (memory read, then compare in the shared match unit).
// An automatic bind walks the table once per port tried.
// One item is in work at a time; in_ready_o is high only while idle.
// The result register holds the finished item while the receiver stalls, and
// a new item may be accepted meanwhile; its result waits for the register.
// Reset clears all entry flags, so every slot reads unbound and unconnected,
// and sets the registers to all ones and 49152.
module socket_demux_table_unit import sdt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sdt_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sdt_out_t    out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

`include "assert_macros.svh"

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IX = IW'(ENTRIES - 1);

  sdt_state_e state_q, state_d;
  sdt_job_e   job_q, job_d;
  sdt_ctl_t   ctl;
  sdt_in_t    item_q, item_d;
  sdt_out_t   res_q, res_d, out_q;
  logic       out_valid_q;

  logic [IW-1:0] idx_q, idx_d;
  logic [15:0]   port_q, port_d, first_q, first_d, lo_q, lo_d;
  logic          skind_q, skind_d;
  logic [31:0]   invalid_ip_q;
  logic [15:0]   eph_q;

  logic [ENTRIES-1:0] bound_q, conn_q, kind_q, iface_q;
  logic [47:0] loc_mem [ENTRIES];
  logic [47:0] rem_mem [ENTRIES];
  logic [47:0] rd_loc_q, rd_rem_q;

  logic          clr_we, conn_we, bind_we;
  logic [IW-1:0] wr_ix;
  logic [15:0]   bind_port;
  logic          accept, in_range, hit, last, out_load;
  logic [15:0]   lo_c, next_port;
  logic [IW-1:0] in_ix, item_ix;
  sdt_entry_t    entry;
  sdt_query_t    query;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_ix    = IW'(in_i.slot);
  assign item_ix  = IW'(item_q.slot);
  assign in_range = (9'(in_i.slot) < 9'(ENTRIES));
  assign lo_c     = (eph_q < PORT_FLOOR) ? PORT_FLOOR : eph_q;
  assign last     = (idx_q == LAST_IX);
  assign next_port = (port_q == PORT_TOP) ? lo_q : port_q + 16'd1;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign entry = '{bound: bound_q[idx_q], connected: conn_q[idx_q],
                   kind: kind_q[idx_q], has_iface: iface_q[idx_q],
                   lip: rd_loc_q[47:16], lport: rd_loc_q[15:0],
                   rip: rd_rem_q[47:16], rport: rd_rem_q[15:0]};
  assign query = '{kind: skind_q, lip: item_q.own_ip, lport: port_q,
                   rip: item_q.peer_ip, rport: item_q.peer_port,
                   full: (item_q.opcode == OP_LOOKUP_FULL)};

  sdt_match u_match (
    .entry_i (entry),
    .query_i (query),
    .hit_o   (hit)
  );

  always_comb begin
    item_d  = item_q;
    job_d   = job_q;
    idx_d   = idx_q;
    port_d  = port_q;
    first_d = first_q;
    lo_d    = lo_q;
    skind_d = skind_q;
    res_d   = res_q;
    ctl     = '0;
    clr_we  = 1'b0;
    conn_we = 1'b0;
    bind_we = 1'b0;
    wr_ix   = item_ix;
    bind_port = port_q;
    if (accept) begin
      item_d = in_i;
      wr_ix  = in_ix;
      lo_d   = lo_c;
      res_d  = '{status: STAT_OK, found: 1'b0, match_slot: in_i.slot, bound_port: 16'd0};
      idx_d  = '0;
      if (in_i.opcode <= OP_CONNECT && !in_range) begin
        res_d.status = STAT_NOTFOUND;
        ctl.finish = 1'b1;
      end else begin
        unique case (in_i.opcode)
          OP_OPEN, OP_CLOSE: begin
            clr_we = 1'b1;
            ctl.finish = 1'b1;
          end
          OP_CONNECT: begin
            if (in_i.peer_port == 16'd0 || in_i.peer_ip == invalid_ip_q) begin
              res_d.status = STAT_BADDST;
            end else begin
              conn_we = 1'b1;
            end
            ctl.finish = 1'b1;
          end
          OP_BIND: begin
            skind_d = kind_q[in_ix];
            if (in_i.own_ip != 32'd0 && !in_i.iface_found) begin
              res_d.status = STAT_NOIF;
              ctl.finish = 1'b1;
            end else if (in_i.own_port == 16'd0) begin
              first_d = (in_i.scan_from < lo_c) ? lo_c : in_i.scan_from;
              port_d  = first_d;
              job_d   = JOB_AUTO;
              ctl.start_scan = 1'b1;
            end else begin
              port_d = in_i.own_port;
              job_d  = JOB_FIXED;
              ctl.start_scan = 1'b1;
            end
          end
          OP_LOOKUP_FULL, OP_LOOKUP_LOC: begin
            skind_d = in_i.sock_kind;
            port_d  = in_i.own_port;
            job_d   = JOB_LOOKUP;
            ctl.start_scan = 1'b1;
          end
          default: begin
            ctl.finish = 1'b1;
          end
        endcase
      end
    end else if (state_q == ST_CMP) begin
      unique case (job_q)
        JOB_LOOKUP: begin
          if (hit) begin
            res_d.status = STAT_OK;
            res_d.found = 1'b1;
            res_d.match_slot = 4'(idx_q);
            ctl.finish = 1'b1;
          end else if (last) begin
            res_d.status = STAT_NOTFOUND;
            res_d.match_slot = 4'd0;
            ctl.finish = 1'b1;
          end else begin
            ctl.next_entry = 1'b1;
          end
        end
        JOB_AUTO: begin
          if (hit) begin
            if (next_port == first_q) begin
              res_d.status = STAT_EXHAUSTED;
              ctl.finish = 1'b1;
            end else begin
              port_d = next_port;
              idx_d  = '0;
              ctl.rescan = 1'b1;
            end
          end else if (last) begin
            bind_we = 1'b1;
            res_d.bound_port = port_q;
            ctl.finish = 1'b1;
          end else begin
            ctl.next_entry = 1'b1;
          end
        end
        JOB_FIXED: begin
          if (hit && idx_q != item_ix) begin
            res_d.status = STAT_INUSE;
            ctl.finish = 1'b1;
          end else if (hit || last) begin
            bind_we = 1'b1;
            res_d.bound_port = port_q;
            ctl.finish = 1'b1;
          end else begin
            ctl.next_entry = 1'b1;
          end
        end
        default: begin
          ctl.finish = 1'b1;
        end
      endcase
      if (ctl.next_entry) begin
        idx_d = idx_q + IW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctl.start_scan) begin
          state_d = ST_READ;
        end else if (ctl.finish) begin
          state_d = ST_FIN;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (ctl.finish) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      job_q        <= JOB_LOOKUP;
      out_valid_q  <= 1'b0;
      invalid_ip_q <= 32'hFFFF_FFFF;
      eph_q        <= PORT_LOW_DEFAULT;
      bound_q      <= '0;
      conn_q       <= '0;
      kind_q       <= '0;
      iface_q      <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == CFG_INVALID_IP) begin
        invalid_ip_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_EPH_START) begin
        eph_q <= cfg_wdata_i[15:0];
      end
      if (clr_we) begin
        bound_q[wr_ix] <= 1'b0;
        conn_q[wr_ix]  <= 1'b0;
        iface_q[wr_ix] <= 1'b0;
        kind_q[wr_ix]  <= (in_i.opcode == OP_OPEN) ? in_i.sock_kind : 1'b0;
      end
      if (conn_we) begin
        conn_q[wr_ix] <= 1'b1;
      end
      if (bind_we) begin
        bound_q[wr_ix] <= 1'b1;
        iface_q[wr_ix] <= (item_q.own_ip != 32'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    idx_q    <= idx_d;
    port_q   <= port_d;
    first_q  <= first_d;
    lo_q     <= lo_d;
    skind_q  <= skind_d;
    res_q    <= res_d;
    rd_loc_q <= loc_mem[idx_q];
    rd_rem_q <= rem_mem[idx_q];
    if (out_load) begin
      out_q <= res_q;
    end
    if (bind_we) begin
      loc_mem[wr_ix] <= {item_q.own_ip, bind_port};
    end
    if (conn_we) begin
      rem_mem[wr_ix] <= {in_i.peer_ip, in_i.peer_port};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SDT_ASSERT_IMP(a_found_ok, out_valid_o && out_o.found, out_o.status == STAT_OK, "found not ok")
  `SDT_ASSERT_IMP(a_port_bind, out_valid_o && out_o.bound_port != 16'd0, out_o.status == STAT_OK && !out_o.found, "bad port")
  `SDT_ASSERT(a_cmp_alt, (state_q == ST_CMP) |=> (state_q != ST_CMP), "compare twice in a row")
  `SDT_ASSERT(a_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after accept")

endmodule

@@ tb/sv/tb.sv @@
// Testbench for socket_demux_table_unit: directed and random opcode items with
// a scoreboard that predicts each result from its own copy of the entry table.
// Depends on sdt_pkg and the socket_demux_table_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdt_pkg::*;

  localparam int NSLOT = 16;

  class sock_table_sb;
    bit          bnd[NSLOT];
    bit          conn[NSLOT];
    bit          knd[NSLOT];
    bit          ifc[NSLOT];
    logic [31:0] lip_q[NSLOT];
    logic [15:0] lport_q[NSLOT];
    logic [31:0] rip_q[NSLOT];
    logic [15:0] rport_q[NSLOT];
    logic [31:0] bad_ip;
    logic [15:0] eph_lo;
    sdt_out_t    pend_q[$];
    int          errors;

    function new();
      for (int i = 0; i < NSLOT; i++) wipe(i);
      bad_ip = 32'hFFFF_FFFF;
      eph_lo = PORT_LOW_DEFAULT;
      errors = 0;
    endfunction

    function void wipe(int s);
      bnd[s] = 0; conn[s] = 0; knd[s] = 0; ifc[s] = 0;
      lip_q[s] = '0; lport_q[s] = '0; rip_q[s] = '0; rport_q[s] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_INVALID_IP) bad_ip = val;
      else if (idx == CFG_EPH_START) eph_lo = val[15:0];
    endfunction

    function bit loc_hit(int i, bit k, logic [31:0] ip, logic [15:0] p);
      if (!bnd[i] || knd[i] != k || lport_q[i] != p) return 0;
      if (!ifc[i] || ip == 0) return 1;
      return lip_q[i] == ip;
    endfunction

    function bit full_hit(int i, sdt_in_t it);
      if (!loc_hit(i, it.sock_kind, it.own_ip, it.own_port)) return 0;
      if (!conn[i]) return it.peer_ip == 0 && it.peer_port == 0;
      return rip_q[i] == it.peer_ip && rport_q[i] == it.peer_port;
    endfunction

    function int first_holder(bit k, logic [31:0] ip, int p);
      for (int i = 0; i < NSLOT; i++)
        if (loc_hit(i, k, ip, p[15:0])) return i;
      return NSLOT;
    endfunction

    function void note_item(sdt_in_t it);
      sdt_out_t r;
      int s, lo, first, p, port, hit;
      bit k;
      s = it.slot;
      r.status = STAT_OK; r.found = 0; r.match_slot = it.slot; r.bound_port = '0;
      case (it.opcode)
        OP_OPEN, OP_CLOSE: begin
          wipe(s);
          if (it.opcode == OP_OPEN) knd[s] = it.sock_kind;
        end
        OP_BIND: begin
          k = knd[s];
          port = it.own_port;
          if (it.own_ip != 0 && !it.iface_found) begin
            r.status = STAT_NOIF;
          end else begin
            if (port == 0) begin
              lo = (eph_lo < PORT_FLOOR) ? PORT_FLOOR : eph_lo;
              first = (it.scan_from < lo) ? lo : it.scan_from;
              p = first;
              do begin
                if (first_holder(k, it.own_ip, p) == NSLOT) begin
                  port = p;
                  break;
                end
                p = (p >= PORT_TOP) ? lo : p + 1;
              end while (p != first);
              if (port == 0) r.status = STAT_EXHAUSTED;
            end
            if (r.status == STAT_OK) begin
              hit = first_holder(k, it.own_ip, port);
              if (hit != NSLOT && hit != s) begin
                r.status = STAT_INUSE;
              end else begin
                bnd[s] = 1;
                ifc[s] = (it.own_ip != 0);
                lip_q[s] = it.own_ip;
                lport_q[s] = port[15:0];
                r.bound_port = port[15:0];
              end
            end
          end
        end
        OP_CONNECT: begin
          if (it.peer_port == 0 || it.peer_ip == bad_ip) begin
            r.status = STAT_BADDST;
          end else begin
            conn[s] = 1;
            rip_q[s] = it.peer_ip;
            rport_q[s] = it.peer_port;
          end
        end
        OP_LOOKUP_FULL, OP_LOOKUP_LOC: begin
          r.match_slot = '0;
          r.status = STAT_NOTFOUND;
          for (int i = 0; i < NSLOT; i++) begin
            if (it.opcode == OP_LOOKUP_FULL ? full_hit(i, it)
                : loc_hit(i, it.sock_kind, it.own_ip, it.own_port)) begin
              r.status = STAT_OK;
              r.found = 1;
              r.match_slot = i[3:0];
              break;
            end
          end
        end
        default: ;
      endcase
      pend_q.push_back(r);
    endfunction

    function void check_result(sdt_out_t got);
      sdt_out_t want;
      if (pend_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pend_q.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.match_slot !== want.match_slot || got.bound_port !== want.bound_port) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  sdt_in_t     in_d = '0;
  logic        out_valid;
  logic        out_ready = 0;
  sdt_out_t    out_d;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  sock_table_sb sb = new();
  bit calm = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  socket_demux_table_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_d),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_d),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_d);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic sdt_in_t mk(logic [2:0] op, logic [3:0] s, logic k, logic [31:0] lip,
                                 logic [15:0] lp, logic [31:0] rip, logic [15:0] rp,
                                 logic ifok, logic [15:0] sp);
    sdt_in_t it;
    it.opcode = op; it.slot = s; it.sock_kind = k; it.own_ip = lip; it.own_port = lp;
    it.peer_ip = rip; it.peer_port = rp; it.iface_found = ifok; it.scan_from = sp;
    return it;
  endfunction

  task automatic send(sdt_in_t it);
    in_d <= it;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pend_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 5))
      0, 1: return 32'h0;
      2: return 32'h0A00_0001;
      3: return 32'h0A00_0002;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    int lo;
    lo = (sb.eph_lo < PORT_FLOOR) ? PORT_FLOOR : sb.eph_lo;
    case ($urandom_range(0, 6))
      0: return 16'd80;
      1: return 16'd443;
      2: return PORT_TOP;
      3, 4: return 16'(lo + $urandom_range(0, 3));
      5: return 16'(lo);
      default: return $urandom();
    endcase
  endfunction

  function automatic sdt_in_t rand_item();
    sdt_in_t it;
    int w, lo;
    lo = (sb.eph_lo < PORT_FLOOR) ? PORT_FLOOR : sb.eph_lo;
    w = $urandom_range(0, 99);
    it.opcode = w < 10 ? OP_OPEN : w < 15 ? OP_CLOSE : w < 45 ? OP_BIND :
                w < 55 ? OP_CONNECT : w < 72 ? OP_LOOKUP_FULL : w < 97 ? OP_LOOKUP_LOC :
                ($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO);
    it.slot = $urandom_range(0, 15);
    it.sock_kind = $urandom_range(0, 1);
    it.own_ip = pick_ip();
    it.own_port = (it.opcode == OP_BIND && $urandom_range(0, 9) < 4) ? 16'd0 : pick_port();
    case ($urandom_range(0, 5))
      0, 1: it.peer_ip = 32'h0;
      2: it.peer_ip = 32'hC0A8_0001;
      3: it.peer_ip = sb.bad_ip;
      default: it.peer_ip = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0, 1: it.peer_port = 16'd0;
      2: it.peer_port = 16'd5000;
      default: it.peer_port = $urandom();
    endcase
    it.iface_found = $urandom_range(0, 9) < 8;
    it.scan_from = $urandom_range(0, 1) ? 16'($urandom()) : 16'(lo + $urandom_range(0, 5));
    return it;
  endfunction

  initial begin
    logic [31:0] cfg_bad[5];
    logic [31:0] cfg_eph[5];
    cfg_bad = '{32'hFFFF_FFFF, 32'h0, 32'hC0A8_0001, 32'h0, 32'hFFFF_FFFF};
    cfg_eph = '{32'd49152, 32'h0, 32'd65530, 32'd65535, 32'd1024};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(mk(OP_OPEN, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_BIND, 0, 0, 0, 16'd80, 0, 0, 0, 0));
    send(mk(OP_BIND, 1, 0, 0, 16'd80, 0, 0, 1, 0));
    send(mk(OP_BIND, 0, 0, 0, 16'd80, 0, 0, 0, 0));
    send(mk(OP_BIND, 2, 0, 32'h0A00_0001, 16'd81, 0, 0, 0, 0));
    send(mk(OP_BIND, 2, 0, 0, 16'd0, 0, 0, 0, 16'd0));
    send(mk(OP_BIND, 3, 0, 0, 16'd0, 0, 0, 0, 16'd49152));
    send(mk(OP_OPEN, 4, 1, 0, 0, 0, 0, 0, 0));
    send(mk(OP_BIND, 4, 1, 32'hFFFF_FFFF, PORT_TOP, 0, 0, 1, 16'hFFFF));
    send(mk(OP_CONNECT, 0, 0, 0, 0, 32'h0A00_0009, 16'd0, 0, 0));
    send(mk(OP_CONNECT, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'd99, 0, 0));
    send(mk(OP_CONNECT, 0, 0, 0, 0, 32'h0A00_0009, PORT_TOP, 0, 0));
    send(mk(OP_LOOKUP_FULL, 0, 0, 0, 16'd80, 32'h0A00_0009, PORT_TOP, 0, 0));
    send(mk(OP_LOOKUP_FULL, 0, 0, 0, 16'd80, 0, 0, 0, 0));
    send(mk(OP_LOOKUP_FULL, 0, 1, 32'hFFFF_FFFF, PORT_TOP, 0, 0, 0, 0));
    send(mk(OP_LOOKUP_LOC, 0, 1, 32'hFFFF_FFFF, PORT_TOP, 0, 0, 0, 0));
    send(mk(OP_LOOKUP_LOC, 0, 1, 32'h0A00_0001, PORT_TOP, 0, 0, 0, 0));
    send(mk(OP_LOOKUP_LOC, 0, 1, 0, PORT_TOP, 0, 0, 0, 0));
    send(mk(OP_SPARE_LO, 15, 1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
            16'hFFFF));
    send(mk(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_LOOKUP_LOC, 0, 0, 0, 16'd80, 0, 0, 0, 0));
    drain();

    write_cfg(CFG_EPH_START, 32'hFFFF_FFFF);
    write_cfg(CFG_SPARE_LO, 32'h1234_5678);
    write_cfg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    send(mk(OP_OPEN, 5, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_BIND, 5, 0, 0, 16'd0, 0, 0, 0, 16'd100));
    send(mk(OP_BIND, 5, 0, 0, 16'd0, 0, 0, 0, 16'd0));
    send(mk(OP_BIND, 6, 0, 0, 16'd0, 0, 0, 0, PORT_TOP));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_INVALID_IP, ph == 2 ? $urandom() : cfg_bad[ph]);
      write_cfg(CFG_EPH_START, ph == 4 ? 32'($urandom_range(1024, 65535)) : cfg_eph[ph]);
      for (int n = 0; n < 400; n++) begin
        if (ph == 4 && n >= 250) calm = 1;
        send(rand_item());
      end
      drain();
    end

    in_valid <= 0;
    while (sb.pend_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pend_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/sdt_pkg.sv
hdl/sdt_match.sv
hdl/socket_demux_table_unit.sv
tb/sv/tb.sv
